// File: hw/rtl/rpn_pkg.sv
// Shared types and command codes of the RPN character stack calculator.
// Depends on nothing; used by rpn_char_stack_calculator_top and its testbench.
package rpn_pkg;

  typedef struct packed {
    logic       operation;
    logic [7:0] character;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] accumulator;
    logic [4:0]         stack_depth;
    logic [31:0]        flag_word;
  } out_req_t;

  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_SHL   = 8'h4C;
  localparam logic [7:0] CH_SHR   = 8'h52;
  localparam logic [7:0] CH_NEG   = 8'h5F;
  localparam logic [7:0] CH_ABS   = 8'h27;
  localparam logic [7:0] CH_SGN   = 8'h24;
  localparam logic [7:0] CH_AND   = 8'h26;
  localparam logic [7:0] CH_OR    = 8'h7C;
  localparam logic [7:0] CH_XOR   = 8'h5E;
  localparam logic [7:0] CH_BOOL  = 8'h23;
  localparam logic [7:0] CH_NOT   = 8'h21;
  localparam logic [7:0] CH_INV   = 8'h7E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_JOIN  = 8'h57;
  localparam logic [7:0] CH_SPLIT = 8'h77;
  localparam logic [7:0] CH_VLD   = 8'h56;
  localparam logic [7:0] CH_VST   = 8'h76;
  localparam logic [7:0] CH_FLD   = 8'h46;
  localparam logic [7:0] CH_FST   = 8'h66;
  localparam logic [7:0] CH_CLD   = 8'h43;
  localparam logic [7:0] CH_CST   = 8'h63;

endpackage

// File: hw/rtl/rpn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/rpn_char_stack_calculator_top.sv
// Top level of the RPN character stack calculator: sequencer, divider, stores.
// Depends on rpn_pkg and rpn_ram.
//
// Usage: each request on the input channel (in_valid_i, in_stall_o, in_req_i)
// is either a reinit (operation = 1: empty the stack, zero the variables) or
// one character. Every request yields exactly one result on the output
// channel (out_valid_o, out_stall_i, out_req_o) holding the accumulator, the
// stack depth and the 32-bit flag word after that request.
// Timing: a request is taken in an idle cycle; the stores are read in that
// cycle and the command executes in the next, so the result is registered at
// the end of the execute cycle. '/' and '%' with a nonzero divisor instead run
// the iterative divider, one quotient bit per cycle, and the result is
// registered as it finishes. The next request is taken only once the command
// finishes, so requests are not overlapped.
// The result sits in an output register; while the receiver stalls it holds
// and a new request is taken only when that register is free or being read.
// Reset clears the accumulator, stack depth, flags, variables and counters;
// no clearing pass is needed, results may be taken right away.
module rpn_char_stack_calculator_top #(
  parameter int STACK_DEPTH  = 16,
  parameter int NUM_VARS     = 16,
  parameter int NUM_COUNTERS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rpn_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rpn_pkg::out_req_t out_req_o
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int VAW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int KAW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
  localparam int VD  = 1 << VAW;
  localparam int KD  = 1 << KAW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV
  } state_e;

  state_e            state_q, state_d;
  rpn_pkg::in_req_t  item_q, item_d;
  logic [15:0]       acc_q, acc_d;
  logic              start_q, start_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [31:0]       flags_q, flags_d;
  logic [NUM_VARS-1:0]     vvld_q, vvld_d;
  logic [NUM_COUNTERS-1:0] kvld_q, kvld_d;
  logic              out_valid_q, out_valid_d;
  rpn_pkg::out_req_t out_q, out_d;
  logic [16:0]       rem_q, rem_d;
  logic [15:0]       quo_q, quo_d;
  logic [15:0]       dvs_q, dvs_d;
  logic [3:0]        dcnt_q, dcnt_d;
  logic              qneg_q, qneg_d;
  logic              rneg_q, rneg_d;
  logic              ismod_q, ismod_d;

  logic              in_accept;
  logic              out_load;
  logic              stk_we;
  logic [SAW-1:0]    stk_waddr;
  logic [15:0]       stk_wdata;
  logic [15:0]       stk_rdata;
  logic [SAW-1:0]    top_addr;
  logic [SAW-1:0]    push_addr;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_inc;
  logic [CW-1:0]     cnt_dec;
  logic              var_we;
  logic [VAW-1:0]    var_idx;
  logic [15:0]       var_rdata;
  logic              ctr_we;
  logic [KAW-1:0]    ctr_idx;
  logic [7:0]        ctr_wdata;
  logic [7:0]        ctr_rdata;
  logic              var_ok;
  logic              ctr_ok;
  logic              flag_ok;
  logic [15:0]       pop_v;
  logic [16:0]       mag;
  logic              big;
  logic [15:0]       base;
  logic signed [20:0] dig_sum;
  logic [16:0]       div_sh;
  logic [16:0]       div_tr;
  logic [16:0]       rem_nx;
  logic [15:0]       quo_nx;
  logic [15:0]       pop_mag;
  logic [15:0]       acc_mag;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);

  assign cnt_m1    = cnt_q - 1'b1;
  assign top_addr  = cnt_m1[SAW-1:0];
  assign push_addr = (cnt_q < CW'(STACK_DEPTH)) ? cnt_q[SAW-1:0] : top_addr;
  assign cnt_inc   = (cnt_q < CW'(STACK_DEPTH)) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_dec   = (cnt_q == '0) ? cnt_q : cnt_m1;

  assign var_idx = acc_q[VAW-1:0];
  assign ctr_idx = acc_q[KAW-1:0];
  assign var_ok  = {1'b0, acc_q} < 17'(NUM_VARS);
  assign ctr_ok  = {1'b0, acc_q} < 17'(NUM_COUNTERS);
  assign flag_ok = acc_q < 16'd32;

  assign pop_v   = (cnt_q == '0) ? 16'h0000 : stk_rdata;
  assign mag     = acc_q[15] ? (17'h10000 - {1'b0, acc_q}) : {1'b0, acc_q};
  assign big     = mag >= 17'd16;
  assign pop_mag = pop_v[15] ? 16'h0000 - pop_v : pop_v;
  assign acc_mag = mag[15:0];

  assign div_sh = {rem_q[15:0], quo_q[15]};
  assign div_tr = div_sh - {1'b0, dvs_q};
  assign rem_nx = div_tr[16] ? div_sh : div_tr;
  assign quo_nx = {quo_q[14:0], ~div_tr[16]};

  rpn_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (top_addr),
    .rdata_o (stk_rdata)
  );

  rpn_ram #(.WIDTH(16), .DEPTH(VD)) u_vars (
    .clk_i   (clk_i),
    .we_i    (var_we),
    .waddr_i (var_idx),
    .wdata_i (pop_v),
    .raddr_i (var_idx),
    .rdata_o (var_rdata)
  );

  rpn_ram #(.WIDTH(8), .DEPTH(KD)) u_ctrs (
    .clk_i   (clk_i),
    .we_i    (ctr_we),
    .waddr_i (ctr_idx),
    .wdata_i (ctr_wdata),
    .raddr_i (ctr_idx),
    .rdata_o (ctr_rdata)
  );

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    acc_d     = acc_q;
    start_d   = start_q;
    cnt_d     = cnt_q;
    flags_d   = flags_q;
    vvld_d    = vvld_q;
    kvld_d    = kvld_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dvs_d     = dvs_q;
    dcnt_d    = dcnt_q;
    qneg_d    = qneg_q;
    rneg_d    = rneg_q;
    ismod_d   = ismod_q;
    out_load  = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = push_addr;
    stk_wdata = acc_q;
    var_we    = 1'b0;
    ctr_we    = 1'b0;
    ctr_wdata = pop_v[15] ? 8'h00 : ((pop_v > 16'd255) ? 8'hFF : pop_v[7:0]);
    base      = acc_q;
    dig_sum   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          item_d  = in_req_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d  = ST_IDLE;
        out_load = 1'b1;
        if (item_q.operation) begin
          cnt_d  = '0;
          vvld_d = '0;
        end else begin
          start_d = 1'b1;
          case (item_q.character) inside
            [rpn_pkg::CH_DIG0:rpn_pkg::CH_DIG9]: begin
              if (start_q) begin
                stk_we = 1'b1;
                cnt_d  = cnt_inc;
                base   = 16'h0000;
              end
              dig_sum = (21'($signed(base)) * 21'sd10)
                        + 21'($signed({1'b0, item_q.character[3:0]}));
              acc_d   = (dig_sum > 21'sd32767) ? 16'h7FFF : dig_sum[15:0];
              start_d = 1'b0;
            end
            rpn_pkg::CH_COMMA: begin
              stk_we  = 1'b1;
              cnt_d   = cnt_inc;
              acc_d   = 16'h0000;
              start_d = 1'b0;
            end
            rpn_pkg::CH_SPLIT: begin
              stk_we    = 1'b1;
              stk_wdata = {8'h00, acc_q[15:8]};
              cnt_d     = cnt_inc;
              acc_d     = {8'h00, acc_q[7:0]};
            end
            rpn_pkg::CH_QUOTE: begin
              if (cnt_q == '0) begin
                acc_d = 16'h0000;
              end else begin
                stk_we    = 1'b1;
                stk_waddr = top_addr;
                acc_d     = stk_rdata;
              end
            end
            rpn_pkg::CH_AT: begin
              cnt_d = cnt_dec;
              acc_d = pop_v;
            end
            rpn_pkg::CH_ADD: begin
              cnt_d = cnt_dec;
              acc_d = pop_v + acc_q;
            end
            rpn_pkg::CH_SUB: begin
              cnt_d = cnt_dec;
              acc_d = pop_v - acc_q;
            end
            rpn_pkg::CH_MUL: begin
              cnt_d = cnt_dec;
              acc_d = 16'(pop_v * acc_q);
            end
            rpn_pkg::CH_DIV, rpn_pkg::CH_MOD: begin
              cnt_d = cnt_dec;
              if (acc_q == 16'h0000) begin
                if (item_q.character == rpn_pkg::CH_DIV) begin
                  acc_d = pop_v[15] ? 16'h8000 : 16'h7FFF;
                end
              end else begin
                state_d  = ST_DIV;
                out_load = 1'b0;
                rem_d    = '0;
                quo_d    = pop_mag;
                dvs_d    = acc_mag;
                dcnt_d   = 4'hF;
                qneg_d   = pop_v[15] ^ acc_q[15];
                rneg_d   = pop_v[15];
                ismod_d  = (item_q.character == rpn_pkg::CH_MOD);
              end
            end
            rpn_pkg::CH_SHL: begin
              cnt_d = cnt_dec;
              acc_d = big ? 16'h0000 : (pop_v << mag[3:0]);
            end
            rpn_pkg::CH_SHR: begin
              cnt_d = cnt_dec;
              if (mag != 17'd0) begin
                acc_d = big ? 16'h0000 : (pop_v >> mag[3:0]);
              end
            end
            rpn_pkg::CH_NEG:  acc_d = 16'h0000 - acc_q;
            rpn_pkg::CH_ABS:  acc_d = acc_mag;
            rpn_pkg::CH_SGN: begin
              acc_d = acc_q[15] ? 16'hFFFF : ((acc_q != 16'h0000) ? 16'h0001 : 16'h0000);
            end
            rpn_pkg::CH_AND: begin
              cnt_d = cnt_dec;
              acc_d = acc_q & pop_v;
            end
            rpn_pkg::CH_OR: begin
              cnt_d = cnt_dec;
              acc_d = acc_q | pop_v;
            end
            rpn_pkg::CH_XOR: begin
              cnt_d = cnt_dec;
              acc_d = acc_q ^ pop_v;
            end
            rpn_pkg::CH_BOOL: acc_d = {15'h0000, acc_q != 16'h0000};
            rpn_pkg::CH_NOT:  acc_d = {15'h0000, acc_q == 16'h0000};
            rpn_pkg::CH_INV:  acc_d = ~acc_q;
            rpn_pkg::CH_EQ: begin
              cnt_d = cnt_dec;
              acc_d = {15'h0000, pop_v == acc_q};
            end
            rpn_pkg::CH_LT: begin
              cnt_d = cnt_dec;
              acc_d = {15'h0000, $signed(pop_v) < $signed(acc_q)};
            end
            rpn_pkg::CH_GT: begin
              cnt_d = cnt_dec;
              acc_d = {15'h0000, $signed(pop_v) > $signed(acc_q)};
            end
            rpn_pkg::CH_JOIN: begin
              cnt_d = cnt_dec;
              acc_d = {pop_v[7:0], acc_q[7:0]};
            end
            rpn_pkg::CH_VLD: begin
              acc_d = (var_ok && vvld_q[var_idx]) ? var_rdata : 16'h0000;
            end
            rpn_pkg::CH_VST: begin
              cnt_d = cnt_dec;
              if (var_ok) begin
                var_we          = 1'b1;
                vvld_d[var_idx] = 1'b1;
              end
            end
            rpn_pkg::CH_FLD: begin
              acc_d = flag_ok ? {15'h0000, flags_q[~acc_q[4:0]]} : 16'h0000;
            end
            rpn_pkg::CH_FST: begin
              cnt_d = cnt_dec;
              if (flag_ok) begin
                flags_d[~acc_q[4:0]] = (pop_v != 16'h0000);
              end
            end
            rpn_pkg::CH_CLD: begin
              acc_d = (ctr_ok && kvld_q[ctr_idx]) ? {8'h00, ctr_rdata} : 16'h0000;
            end
            rpn_pkg::CH_CST: begin
              cnt_d = cnt_dec;
              if (ctr_ok) begin
                ctr_we          = 1'b1;
                kvld_d[ctr_idx] = 1'b1;
              end
            end
            default: start_d = start_q;
          endcase
        end
      end
      ST_DIV: begin
        rem_d  = rem_nx;
        quo_d  = quo_nx;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == 4'h0) begin
          state_d  = ST_IDLE;
          out_load = 1'b1;
          if (ismod_q) begin
            acc_d = rneg_q ? 16'h0000 - rem_nx[15:0] : rem_nx[15:0];
          end else begin
            acc_d = qneg_q ? 16'h0000 - quo_nx : quo_nx;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d       = 1'b1;
      out_d.accumulator = acc_d;
      out_d.stack_depth = 5'(cnt_d);
      out_d.flag_word   = flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      acc_q       <= '0;
      start_q     <= 1'b0;
      cnt_q       <= '0;
      flags_q     <= '0;
      vvld_q      <= '0;
      kvld_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      dvs_q       <= '0;
      dcnt_q      <= '0;
      qneg_q      <= 1'b0;
      rneg_q      <= 1'b0;
      ismod_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      acc_q       <= acc_d;
      start_q     <= start_d;
      cnt_q       <= cnt_d;
      flags_q     <= flags_d;
      vvld_q      <= vvld_d;
      kvld_q      <= kvld_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      rem_q       <= rem_d;
      quo_q       <= quo_d;
      dvs_q       <= dvs_d;
      dcnt_q      <= dcnt_d;
      qneg_q      <= qneg_d;
      rneg_q      <= rneg_d;
      ismod_q     <= ismod_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_EXEC)
    else $error("accepted request did not enter execute");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && dcnt_q == 4'h0) |=> out_valid_o && state_q == ST_IDLE)
    else $error("divider finish did not produce a result");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("result overwrote a stalled result");

endmodule

// File: test/rpn_char_stack_calculator_top_tb.sv
// Testbench of the RPN character stack calculator: directed and random character
// streams with sender idling and receiver stalls, checked against a predictor.
// Depends on rpn_pkg and rpn_char_stack_calculator_top.
module rpn_char_stack_calculator_top_tb;
  import rpn_pkg::*;

  localparam int DEPTH = 16;
  localparam int NVARS = 16;
  localparam int NCNT  = 8;

  class calc_scoreboard;
    logic [15:0] acc;
    bit          fresh_num;
    logic [15:0] stk [DEPTH];
    int          depth;
    logic [15:0] vars [NVARS];
    logic [31:0] flags;
    logic [7:0]  cnt [NCNT];
    out_req_t    pending_q[$];
    int          errors;

    function void clear();
      acc = '0; fresh_num = 0; depth = 0; flags = '0; errors = 0;
      foreach (vars[i]) vars[i] = '0;
      foreach (cnt[i]) cnt[i] = '0;
      foreach (stk[i]) stk[i] = '0;
    endfunction

    function void push(logic [15:0] v);
      if (depth < DEPTH) depth++;
      stk[depth - 1] = v;
    endfunction

    function logic [15:0] pop();
      if (depth == 0) return '0;
      depth--;
      return stk[depth];
    endfunction

    function void exec_char(logic [7:0] c);
      int a, p, mag;
      logic [15:0] pu;
      a = $signed(acc);
      if (c >= CH_DIG0 && c <= CH_DIG9) begin
        if (fresh_num) begin
          push(acc); a = 0; fresh_num = 0;
        end
        p = a * 10 + int'(c - CH_DIG0);
        acc = p > 32767 ? 16'h7FFF : p[15:0];
        return;
      end
      case (c)
        CH_COMMA: begin
          push(acc); acc = '0; fresh_num = 0; return;
        end
        CH_AT: acc = pop();
        CH_QUOTE: begin
          if (depth == 0) acc = '0;
          else begin
            pu = stk[depth - 1]; stk[depth - 1] = acc; acc = pu;
          end
        end
        CH_ADD: begin p = $signed(pop()) + a; acc = p[15:0]; end
        CH_SUB: begin p = $signed(pop()) - a; acc = p[15:0]; end
        CH_MUL: begin p = $signed(pop()) * a; acc = p[15:0]; end
        CH_DIV: begin
          p = $signed(pop());
          if (a == 0) acc = p < 0 ? 16'h8000 : 16'h7FFF;
          else begin p = p / a; acc = p[15:0]; end
        end
        CH_MOD: begin
          p = $signed(pop());
          if (a != 0) begin p = p % a; acc = p[15:0]; end
        end
        CH_SHL: begin
          pu = pop(); mag = a < 0 ? -a : a;
          acc = mag >= 16 ? '0 : 16'(pu << mag);
        end
        CH_SHR: begin
          pu = pop(); mag = a < 0 ? -a : a;
          if (mag != 0) acc = mag >= 16 ? '0 : 16'(pu >> mag);
        end
        CH_NEG: begin p = -a; acc = p[15:0]; end
        CH_ABS: begin p = a < 0 ? -a : a; acc = p[15:0]; end
        CH_SGN: acc = a > 0 ? 16'd1 : (a < 0 ? 16'hFFFF : 16'd0);
        CH_AND: acc = acc & pop();
        CH_OR:  acc = acc | pop();
        CH_XOR: acc = acc ^ pop();
        CH_BOOL: acc = {15'd0, a != 0};
        CH_NOT:  acc = {15'd0, a == 0};
        CH_INV:  acc = ~acc;
        CH_EQ: acc = {15'd0, $signed(pop()) == a};
        CH_LT: acc = {15'd0, $signed(pop()) < a};
        CH_GT: acc = {15'd0, $signed(pop()) > a};
        CH_JOIN: begin pu = pop(); acc = {pu[7:0], acc[7:0]}; end
        CH_SPLIT: begin push({8'd0, acc[15:8]}); acc = {8'd0, acc[7:0]}; end
        CH_VLD: acc = (a >= 0 && a < NVARS) ? vars[a] : '0;
        CH_VST: begin pu = pop(); if (a >= 0 && a < NVARS) vars[a] = pu; end
        CH_FLD: acc = (a >= 0 && a < 32) ? {15'd0, flags[31 - a]} : '0;
        CH_FST: begin
          pu = pop();
          if (a >= 0 && a < 32) flags[31 - a] = pu != 0;
        end
        CH_CLD: acc = (a >= 0 && a < NCNT) ? {8'd0, cnt[a]} : '0;
        CH_CST: begin
          p = $signed(pop());
          if (a >= 0 && a < NCNT) cnt[a] = p < 0 ? 8'd0 : (p > 255 ? 8'd255 : p[7:0]);
        end
        default: return;
      endcase
      fresh_num = 1;
    endfunction

    function void note_request(in_req_t r);
      out_req_t e;
      if (r.operation) begin
        depth = 0;
        foreach (vars[i]) vars[i] = '0;
      end else exec_char(r.character);
      e.accumulator = acc;
      e.stack_depth = depth[4:0];
      e.flag_word = flags;
      pending_q.push_back(e);
    endfunction

    function void check_result(out_req_t got);
      out_req_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result acc=%0d depth=%0d flags=%h", $time,
                 got.accumulator, got.stack_depth, got.flag_word);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.accumulator !== e.accumulator) begin
        $display("%0t: accumulator expected %0d actual %0d", $time,
                 e.accumulator, got.accumulator);
        errors++;
      end
      if (got.stack_depth !== e.stack_depth) begin
        $display("%0t: stack_depth expected %0d actual %0d", $time,
                 e.stack_depth, got.stack_depth);
        errors++;
      end
      if (got.flag_word !== e.flag_word) begin
        $display("%0t: flag_word expected %h actual %h", $time, e.flag_word, got.flag_word);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i = 0;
  logic     rst_ni = 0;
  logic     in_valid_i = 0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 0;
  out_req_t out_req_o;

  int idle_pct = 0;
  int stall_pct = 0;
  calc_scoreboard calc_sb;

  rpn_char_stack_calculator_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_req_o
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) calc_sb.check_result(out_req_o);
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  logic [7:0] cmd_set [] = '{CH_COMMA, CH_AT, CH_QUOTE, CH_ADD, CH_SUB, CH_MUL, CH_DIV,
    CH_MOD, CH_SHL, CH_SHR, CH_NEG, CH_ABS, CH_SGN, CH_AND, CH_OR, CH_XOR, CH_BOOL,
    CH_NOT, CH_INV, CH_EQ, CH_LT, CH_GT, CH_JOIN, CH_SPLIT, CH_VLD, CH_VST, CH_FLD,
    CH_FST, CH_CLD, CH_CST};

  task automatic send_request(bit op, logic [7:0] ch);
    in_req_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      in_req_i <= in_req_t'(9'($urandom));
      @(negedge clk_i);
    end
    r.operation = op;
    r.character = ch;
    in_req_i <= r;
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    calc_sb.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic send_char(logic [7:0] ch);
    send_request(0, ch);
  endtask

  task automatic send_number(int v);
    string s;
    s = $sformatf("%0d", v);
    send_char(CH_COMMA);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic random_item();
    int k;
    k = $urandom_range(99);
    if (k < 2) send_request(1, 8'($urandom));
    else if (k < 10) send_char(8'($urandom));
    else if (k < 40) send_char(8'(CH_DIG0 + $urandom_range(9)));
    else if (k < 50) send_number($urandom_range(40));
    else send_char(cmd_set[$urandom_range(cmd_set.size() - 1)]);
  endtask

  initial begin
    int idle_tab [4] = '{0, 75, 0, 9};
    int stall_tab [4] = '{0, 0, 75, 9};
    calc_sb = new();
    calc_sb.clear();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    send_char(CH_AT);
    for (int i = 0; i < 6; i++) send_char(CH_DIG9);
    send_char(CH_NEG);
    send_char(CH_ABS);
    send_number(32768);
    send_char(CH_DIG0);
    send_char(CH_DIV);
    send_char(8'hFF);
    send_char(8'h00);
    for (int i = 0; i < 18; i++) send_char(CH_SPLIT);
    send_number(0);
    send_char(CH_MOD);
    send_char(CH_SHR);
    send_request(1, 8'hFF);
    foreach (cmd_set[i]) send_char(cmd_set[i]);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      for (int i = 0; i < 250; i++) random_item();
    end
    in_valid_i <= 0;
    idle_pct = 0;
    stall_pct = 0;
    while (calc_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (calc_sb.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
